// ===== rtl/rdpd_pkg.sv =====
package rdpd_pkg;

    // Frame and region geometry
    localparam int FRAME_WIDTH  = 352;
    localparam int FRAME_HEIGHT = 288;
    localparam int MAX_SIDE     = 63;

    localparam int COORD_W = 9;
    localparam int SIDE_W  = 6;
    localparam int COLOR_W = 8;
    localparam int COUNT_W = 12;
    localparam int AREA_W  = 2 * SIDE_W;
    localparam int PROD_W  = COUNT_W + 3;
    localparam int CFG_W   = COORD_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COLOR_W-1:0] RED_MIN   = COLOR_W'(50);
    localparam logic [COLOR_W-1:0] GB_LIMIT  = COLOR_W'(100);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_B_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_B_W = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_B_H = 3'd7;

    // Reset values
    localparam logic [COORD_W-1:0] RST_A_X = COORD_W'(270);
    localparam logic [COORD_W-1:0] RST_A_Y = COORD_W'(200);
    localparam logic [SIDE_W-1:0]  RST_A_W = SIDE_W'(15);
    localparam logic [SIDE_W-1:0]  RST_A_H = SIDE_W'(15);
    localparam logic [COORD_W-1:0] RST_B_X = COORD_W'(250);
    localparam logic [COORD_W-1:0] RST_B_Y = COORD_W'(255);
    localparam logic [SIDE_W-1:0]  RST_B_W = SIDE_W'(15);
    localparam logic [SIDE_W-1:0]  RST_B_H = SIDE_W'(15);

    typedef struct packed {
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               frame_end;
    } pixel_t;

    typedef struct packed {
        logic hit;
        logic hit_index;
        logic meter_tick;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIDE_W-1:0]  w;
        logic [SIDE_W-1:0]  h;
    } region_cfg_t;

    typedef struct packed {
        region_cfg_t a;
        region_cfg_t b;
    } cfg_t;

    // Classified pixel passed from front to back
    typedef struct packed {
        logic inc_a;
        logic inc_b;
        logic frame_end;
    } token_t;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] r;
        r = s;
        if (32'(s) > MAX_SIDE)
        begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

    function automatic logic in_region(input logic [COORD_W-1:0] px,
                                       input logic [COORD_W-1:0] py,
                                       input region_cfg_t rg);
        logic [COORD_W:0] x_end;
        logic [COORD_W:0] y_end;
        x_end = {1'b0, rg.x} + (COORD_W+1)'(clamp_side(rg.w));
        y_end = {1'b0, rg.y} + (COORD_W+1)'(clamp_side(rg.h));
        return (px >= rg.x) && ({1'b0, px} < x_end) &&
               (py >= rg.y) && ({1'b0, py} < y_end);
    endfunction

endpackage

// ===== rtl/region_dark_pixel_hit_detector_unit.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  rdpd_pkg::pixel_t  (one pixel per request)
// out       output     out_valid/out_stall  rdpd_pkg::result_t (one per frame-end pixel)
// cfg       input      cfg_we               cfg_index, cfg_wdata (8 region registers)
//
// One pixel request is taken every cycle while the queue has room; the front classifies
// it and drops a three-bit token into a four-entry queue, the back drains one token a
// cycle unless a stalled result holds it. A frame-end result passes the queue and the
// output register. Reset (rst_n, async low) clears counters, last-hit memory, queue and
// output valid, and loads the default regions. A stalled result holds the back only on
// the next frame-end token; in_stall rises only when the queue is full.
module region_dark_pixel_hit_detector_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rdpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rdpd_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  rdpd_pkg::pixel_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output rdpd_pkg::result_t              out_data
);

    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    rdpd_pkg::token_t push_tok;
    rdpd_pkg::token_t head;
    rdpd_pkg::cfg_t   cfg;

    // Stall the pixel stream only when the token queue has no room
    assign in_stall = q_full;

    rdpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .q_full    (q_full),
        .push      (push),
        .push_tok  (push_tok),
        .cfg       (cfg)
    );

    rdpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    // Back end: count dark pixels, judge the regions at frame end, hold the result
    rdpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/rdpd_front.sv =====
module rdpd_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rdpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rdpd_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               in_valid,
    input  rdpd_pkg::pixel_t                   in_data,
    input  logic                               q_full,
    output logic                               push,
    output rdpd_pkg::token_t                   push_tok,
    output rdpd_pkg::cfg_t                     cfg
);

    rdpd_pkg::cfg_t cfg_reg;
    rdpd_pkg::cfg_t cfg_next;
    logic on_frame;
    logic dark;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rdpd_pkg::REG_A_X: cfg_next.a.x = cfg_wdata;
                rdpd_pkg::REG_A_Y: cfg_next.a.y = cfg_wdata;
                rdpd_pkg::REG_A_W: cfg_next.a.w = cfg_wdata[rdpd_pkg::SIDE_W-1:0];
                rdpd_pkg::REG_A_H: cfg_next.a.h = cfg_wdata[rdpd_pkg::SIDE_W-1:0];
                rdpd_pkg::REG_B_X: cfg_next.b.x = cfg_wdata;
                rdpd_pkg::REG_B_Y: cfg_next.b.y = cfg_wdata;
                rdpd_pkg::REG_B_W: cfg_next.b.w = cfg_wdata[rdpd_pkg::SIDE_W-1:0];
                rdpd_pkg::REG_B_H: cfg_next.b.h = cfg_wdata[rdpd_pkg::SIDE_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.a.x <= rdpd_pkg::RST_A_X;
            cfg_reg.a.y <= rdpd_pkg::RST_A_Y;
            cfg_reg.a.w <= rdpd_pkg::RST_A_W;
            cfg_reg.a.h <= rdpd_pkg::RST_A_H;
            cfg_reg.b.x <= rdpd_pkg::RST_B_X;
            cfg_reg.b.y <= rdpd_pkg::RST_B_Y;
            cfg_reg.b.w <= rdpd_pkg::RST_B_W;
            cfg_reg.b.h <= rdpd_pkg::RST_B_H;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify the pixel: on the frame, dark, and which regions hold it
    assign on_frame = (32'(in_data.pix_x) < rdpd_pkg::FRAME_WIDTH) &&
                      (32'(in_data.pix_y) < rdpd_pkg::FRAME_HEIGHT);
    assign dark = (in_data.red > rdpd_pkg::RED_MIN) &&
                  (in_data.green < rdpd_pkg::GB_LIMIT) &&
                  (in_data.blue < rdpd_pkg::GB_LIMIT);

    assign push = in_valid && !q_full;
    assign push_tok.inc_a = on_frame && dark &&
                            rdpd_pkg::in_region(in_data.pix_x, in_data.pix_y, cfg_reg.a);
    assign push_tok.inc_b = on_frame && dark &&
                            rdpd_pkg::in_region(in_data.pix_x, in_data.pix_y, cfg_reg.b);
    assign push_tok.frame_end = in_data.frame_end;
    assign cfg = cfg_reg;

endmodule

// ===== rtl/rdpd_queue.sv =====
module rdpd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rdpd_pkg::token_t push_tok,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output rdpd_pkg::token_t head
);

    rdpd_pkg::token_t mem_reg [rdpd_pkg::QUEUE_DEPTH];
    logic [rdpd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rdpd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rdpd_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == rdpd_pkg::QCNT_W'(rdpd_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = rdpd_pkg::QPTR_W'((32'(wr_ptr_reg) + 1) % rdpd_pkg::QUEUE_DEPTH);
        end
        if (pop)
        begin
            rd_ptr_next = rdpd_pkg::QPTR_W'((32'(rd_ptr_reg) + 1) % rdpd_pkg::QUEUE_DEPTH);
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= rdpd_pkg::QUEUE_DEPTH)
        else $error("queue count out of range");
`endif

endmodule

// ===== rtl/rdpd_back.sv =====
module rdpd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  rdpd_pkg::cfg_t   cfg,
    input  logic             q_empty,
    input  rdpd_pkg::token_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output rdpd_pkg::result_t out_data
);

    logic [rdpd_pkg::COUNT_W-1:0] cnt_a_reg, cnt_a_next, cnt_a_inc;
    logic [rdpd_pkg::COUNT_W-1:0] cnt_b_reg, cnt_b_next, cnt_b_inc;
    logic [rdpd_pkg::AREA_W-1:0]  area_a_reg, area_b_reg;
    logic [rdpd_pkg::AREA_W-1:0]  area_a_next, area_b_next;
    logic last_valid_reg, last_valid_next;
    logic last_index_reg, last_index_next;
    logic out_valid_reg, out_valid_next;
    rdpd_pkg::result_t out_data_reg, out_data_next;
    logic out_free;
    logic pass_a, pass_b;
    rdpd_pkg::result_t res;

    // Areas track cfg; user keeps configuration static while work is pending (unchecked)
    assign area_a_next = rdpd_pkg::AREA_W'(rdpd_pkg::clamp_side(cfg.a.w)) *
                         rdpd_pkg::AREA_W'(rdpd_pkg::clamp_side(cfg.a.h));
    assign area_b_next = rdpd_pkg::AREA_W'(rdpd_pkg::clamp_side(cfg.b.w)) *
                         rdpd_pkg::AREA_W'(rdpd_pkg::clamp_side(cfg.b.h));

    assign out_free = !out_valid_reg || !out_stall;
    assign pop = !q_empty && (!head.frame_end || out_free);

    // Saturating count including the current pixel
    assign cnt_a_inc = (head.inc_a && cnt_a_reg != rdpd_pkg::COUNT_MAX) ?
                       cnt_a_reg + 1'b1 : cnt_a_reg;
    assign cnt_b_inc = (head.inc_b && cnt_b_reg != rdpd_pkg::COUNT_MAX) ?
                       cnt_b_reg + 1'b1 : cnt_b_reg;

    // 5*count > 4*area
    assign pass_a = ({cnt_a_inc, 2'b00} + rdpd_pkg::PROD_W'(cnt_a_inc)) >
                    rdpd_pkg::PROD_W'({area_a_reg, 2'b00});
    assign pass_b = ({cnt_b_inc, 2'b00} + rdpd_pkg::PROD_W'(cnt_b_inc)) >
                    rdpd_pkg::PROD_W'({area_b_reg, 2'b00});

    always_comb
    begin
        res.hit        = pass_a || pass_b;
        res.hit_index  = !pass_a && pass_b;
        res.meter_tick = res.hit && (!last_valid_reg || last_index_reg != res.hit_index);
    end

    always_comb
    begin
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        last_valid_next = last_valid_reg;
        last_index_next = last_index_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        if (pop)
        begin
            if (head.frame_end)
            begin
                cnt_a_next     = '0;
                cnt_b_next     = '0;
                out_valid_next = 1'b1;
                out_data_next  = res;
                if (res.meter_tick)
                begin
                    last_valid_next = 1'b1;
                    last_index_next = res.hit_index;
                end
            end
            else
            begin
                cnt_a_next = cnt_a_inc;
                cnt_b_next = cnt_b_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            last_valid_reg <= 1'b0;
            last_index_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            last_valid_reg <= last_valid_next;
            last_index_reg <= last_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        area_a_reg   <= area_a_next;
        area_b_reg   <= area_b_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_tick_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.hit || (!out_data_reg.meter_tick &&
                                                !out_data_reg.hit_index)))
        else $error("tick or index without hit");
    a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.frame_end) |=> (cnt_a_reg == '0 && cnt_b_reg == '0))
        else $error("counters not cleared at frame end");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.frame_end) |-> out_free)
        else $error("result overwritten while stalled");
    a_tick_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.frame_end && res.meter_tick) |=>
            (last_valid_reg && last_index_reg == out_data_reg.hit_index))
        else $error("last hit not recorded");
`endif

endmodule
